// File: src/nonoverlap_occurrence_counter_defines.svh
// Assertion macros shared by the occurrence counter RTL.
`ifndef NONOVERLAP_OCCURRENCE_COUNTER_DEFINES_SVH
`define NONOVERLAP_OCCURRENCE_COUNTER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define NOC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define NOC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/noc_pkg.sv
// Package with the shared constants of the occurrence counter.
package noc_pkg;

  localparam int unsigned MAX_LAYERS_DEF = 8;
  localparam int unsigned LIST_DEPTH_DEF = 256;
  localparam int unsigned POS_WIDTH_DEF  = 16;

  localparam int unsigned CFG_W   = 4;
  localparam int unsigned LAYER_W = 3;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned TOTAL_W = 32;

  localparam logic [CFG_W-1:0] PLEN_RESET = 4'd2;
  localparam int unsigned      PLEN_MIN   = 2;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_CLOSE  = 1'b1
  } opcode_e;

endpackage

// File: src/nonoverlap_occurrence_counter.sv
// Top level of the non-overlapping pattern occurrence counter.
//
// Input transactions either append a position to one layer's list or close the
// current sequence. A close starts a greedy chain search that reads the stored
// lists from one position RAM through one comparator pair: each layer-0 entry
// it visits is read in the M_RD and M_CHK states, and each candidate scanned in
// a later layer in the K_RD and K_CHK states. A layer whose list runs out ends
// the search. The done state then hands the result to the output register.
// After a close is taken, input stall stays high through the search and the
// done state, including any wait for a stalled output register to free up.
// The result is valid from the first cycle in which input stall is low again.
// One output transaction is produced per close, none per append. The output
// register holds its transaction while the receiver stalls; appends are still
// taken meanwhile, while the next close waits for the register to free up.
// The pattern length register may be written whenever the block is idle.
// Reset empties all lists, clears the running total and the overflow flag, and
// sets the pattern length to two. The position RAM itself is never cleared:
// only entries below a layer's fill count are ever read.
`include "nonoverlap_occurrence_counter_defines.svh"

module nonoverlap_occurrence_counter #(
  parameter int unsigned MAX_LAYERS = noc_pkg::MAX_LAYERS_DEF,
  parameter int unsigned LIST_DEPTH = noc_pkg::LIST_DEPTH_DEF,
  parameter int unsigned POS_WIDTH  = noc_pkg::POS_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [noc_pkg::CFG_W-1:0]    cfg_pattern_length_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         opcode_i,
  input  logic [noc_pkg::LAYER_W-1:0]  layer_i,
  input  logic [POS_WIDTH-1:0]         position_i,
  input  logic                         last_sequence_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [noc_pkg::COUNT_W-1:0]  sequence_count_o,
  output logic [noc_pkg::TOTAL_W-1:0]  total_count_o,
  output logic                         list_overflow_o,
  output logic                         final_res_o
);

  import noc_pkg::*;

  localparam int unsigned LAY_W  = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int unsigned IDX_W  = $clog2(LIST_DEPTH);
  localparam int unsigned FILL_W = $clog2(LIST_DEPTH + 1);
  localparam int unsigned PLEN_W = $clog2(MAX_LAYERS + 1);
  localparam int unsigned CW     = (PLEN_W > CFG_W) ? PLEN_W : CFG_W;
  localparam int unsigned RAM_AW = LAY_W + IDX_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_M_RD  = 3'd1;
  localparam logic [2:0] S_M_CHK = 3'd2;
  localparam logic [2:0] S_K_RD  = 3'd3;
  localparam logic [2:0] S_K_CHK = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]           state_q, state_d;
  logic [CFG_W-1:0]     plen_q;
  logic [FILL_W-1:0]    fill_q [MAX_LAYERS];
  logic [FILL_W-1:0]    fill_d [MAX_LAYERS];
  logic [POS_WIDTH-1:0] last_q [MAX_LAYERS];
  logic [POS_WIDTH-1:0] last_d [MAX_LAYERS];
  logic [MAX_LAYERS-1:0] cv_q, cv_d;
  logic                 ovf_q, ovf_d;
  logic [TOTAL_W-1:0]   total_q, total_d;
  logic [COUNT_W-1:0]   seq_q, seq_d;
  logic [FILL_W-1:0]    m_q, m_d;
  logic [FILL_W-1:0]    k_q, k_d;
  logic [LAY_W-1:0]     j_q, j_d;
  logic [POS_WIDTH-1:0] prev_q, prev_d;
  logic                 fin_q, fin_d;

  logic                 out_valid_q;
  logic [COUNT_W-1:0]   out_seq_q;
  logic [TOTAL_W-1:0]   out_total_q;
  logic                 out_ovf_q;
  logic                 out_fin_q;

  logic [CW-1:0]        plen_eff;
  logic [LAY_W-1:0]     j_last;
  logic [LAY_W-1:0]     lay_idx;
  logic                 lay_ok;
  logic [LAY_W-1:0]     fill_idx;
  logic [FILL_W-1:0]    fill_cur;
  logic                 in_acc;
  logic                 emit;
  logic                 hit;
  logic [FILL_W-1:0]    m_next;

  logic                 ram_we;
  logic [RAM_AW-1:0]    ram_waddr;
  logic [RAM_AW-1:0]    ram_raddr;
  logic [POS_WIDTH-1:0] ram_rdata;

  always_comb begin
    plen_eff = CW'(plen_q);
    if (plen_eff < CW'(PLEN_MIN)) begin
      plen_eff = CW'(PLEN_MIN);
    end else if (plen_eff > CW'(MAX_LAYERS)) begin
      plen_eff = CW'(MAX_LAYERS);
    end
    j_last = LAY_W'(plen_eff - CW'(1));
  end

  assign lay_idx  = LAY_W'(layer_i);
  assign lay_ok   = 32'(layer_i) < 32'(MAX_LAYERS);
  assign fill_idx = (state_q == S_IDLE) ? lay_idx : j_q;
  assign fill_cur = fill_q[fill_idx];
  assign in_acc   = in_valid_i && !in_stall_o;
  assign emit     = !out_valid_q || !out_stall_i;
  assign m_next   = m_q + FILL_W'(1);

  assign hit = (ram_rdata > prev_q) && (!cv_q[j_q] || (ram_rdata > last_q[j_q]));

  assign ram_we    = in_acc && (opcode_i == OP_APPEND) && lay_ok
                     && (fill_cur != FILL_W'(LIST_DEPTH));
  assign ram_waddr = {lay_idx, fill_cur[IDX_W-1:0]};
  assign ram_raddr = (state_q == S_M_RD) ? {LAY_W'(0), m_q[IDX_W-1:0]}
                                         : {j_q, k_q[IDX_W-1:0]};

  noc_ram #(
    .WIDTH (POS_WIDTH),
    .DEPTH (1 << RAM_AW),
    .AW    (RAM_AW)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (position_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    last_d  = last_q;
    cv_d    = cv_q;
    ovf_d   = ovf_q;
    total_d = total_q;
    seq_d   = seq_q;
    m_d     = m_q;
    k_d     = k_q;
    j_d     = j_q;
    prev_d  = prev_q;
    fin_d   = fin_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (opcode_i == OP_CLOSE) begin
            fin_d = last_sequence_i;
            m_d   = '0;
            if (fill_q[0] == '0) begin
              state_d = S_DONE;
            end else begin
              state_d = S_M_RD;
            end
          end else if (lay_ok) begin
            if (fill_cur == FILL_W'(LIST_DEPTH)) begin
              ovf_d = 1'b1;
            end else begin
              fill_d[lay_idx] = fill_cur + FILL_W'(1);
            end
          end
        end
      end
      S_M_RD: begin
        state_d = S_M_CHK;
      end
      S_M_CHK: begin
        prev_d  = ram_rdata;
        j_d     = LAY_W'(1);
        k_d     = '0;
        state_d = S_K_RD;
      end
      S_K_RD: begin
        if (k_q == fill_cur) begin
          state_d = S_DONE;
        end else begin
          state_d = S_K_CHK;
        end
      end
      S_K_CHK: begin
        if (hit) begin
          last_d[j_q] = ram_rdata;
          cv_d[j_q]   = 1'b1;
          prev_d      = ram_rdata;
          k_d         = '0;
          if (j_q == j_last) begin
            seq_d = seq_q + COUNT_W'(1);
            if (total_q != '1) begin
              total_d = total_q + TOTAL_W'(1);
            end
            m_d = m_next;
            if (m_next == fill_q[0]) begin
              state_d = S_DONE;
            end else begin
              state_d = S_M_RD;
            end
          end else begin
            j_d     = j_q + LAY_W'(1);
            state_d = S_K_RD;
          end
        end else begin
          k_d     = k_q + FILL_W'(1);
          state_d = S_K_RD;
        end
      end
      S_DONE: begin
        if (emit) begin
          for (int i = 0; i < MAX_LAYERS; i++) begin
            fill_d[i] = '0;
          end
          cv_d    = '0;
          ovf_d   = 1'b0;
          seq_d   = '0;
          if (fin_q) begin
            total_d = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      plen_q      <= PLEN_RESET;
      for (int i = 0; i < MAX_LAYERS; i++) begin
        fill_q[i] <= '0;
      end
      cv_q        <= '0;
      ovf_q       <= 1'b0;
      total_q     <= '0;
      seq_q       <= '0;
      m_q         <= '0;
      k_q         <= '0;
      j_q         <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      cv_q    <= cv_d;
      ovf_q   <= ovf_d;
      total_q <= total_d;
      seq_q   <= seq_d;
      m_q     <= m_d;
      k_q     <= k_d;
      j_q     <= j_d;
      fin_q   <= fin_d;
      if (cfg_valid_i && cfg_ready_o) begin
        plen_q <= cfg_pattern_length_i;
      end
      if (state_q == S_DONE && emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    prev_q <= prev_d;
    if (state_q == S_DONE && emit) begin
      out_seq_q   <= seq_q;
      out_total_q <= total_q;
      out_ovf_q   <= ovf_q;
      out_fin_q   <= fin_q;
    end
  end

  assign cfg_ready_o      = 1'b1;
  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign sequence_count_o = out_seq_q;
  assign total_count_o    = out_total_q;
  assign list_overflow_o  = out_ovf_q;
  assign final_res_o      = out_fin_q;

  `NOC_ASSERT_NOW(a_scan_in_range, state_q == S_K_CHK, k_q < fill_cur, "Scan index past list fill.")
  `NOC_ASSERT_NOW(a_outer_in_range, (state_q == S_M_RD) || (state_q == S_M_CHK), m_q < fill_q[0], "Layer-0 index past list fill.")
  `NOC_ASSERT_NEXT(a_done_emits, (state_q == S_DONE) && emit, out_valid_q && (state_q == S_IDLE) && (fill_q[0] == '0), "Close did not emit and clear.")
  `NOC_ASSERT_NOW(a_result_from_search, $rose(out_valid_q), $past(state_q == S_DONE), "Result appeared without a search.")

endmodule

// File: src/noc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module noc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
